>>> src/sal_pkg.sv
// ---------------------------------------------------------------------------
// sal_pkg: shared types and constants of the size-aware lru cache
// Holds the entry and command types of the cell chain, request codes,
// register indexes and the controller states.
// ---------------------------------------------------------------------------
package sal_pkg;

    localparam int unsigned ENTRIES_DEFAULT = 64;
    localparam int unsigned KEY_W   = 64;
    localparam int unsigned SIZE_W  = 32;
    localparam int unsigned BYTES_W = 40;
    localparam int unsigned THR_W   = 34;
    localparam int unsigned EVC_W   = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 40;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 34'd524288;
    localparam logic [EVC_W-1:0] EVC_MAX = 7'd127;

    // request codes
    typedef enum logic [1:0] {
        REQ_ACCESS = 2'd0,
        REQ_EVICT  = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_ENABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd3;

    // one stored object
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } entry_t;

    // operations broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_MATCH,
        OP_REMOVE,
        OP_TO_FRONT,
        OP_INSERT,
        OP_DROP_TAIL
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
    } cell_cmd_t;

    // summary of the chain seen by the controller
    typedef struct packed {
        logic              match_any;
        logic [SIZE_W-1:0] match_size;
        logic [SIZE_W-1:0] tail_size;
        logic              front_valid;
        logic              last_valid;
    } chain_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DECIDE,
        ST_EVICT,
        ST_INSERT,
        ST_DONE
    } ctrl_state_t;

endpackage

>>> src/sal_ifs.sv
// ---------------------------------------------------------------------------
// sal channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sal_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [sal_pkg::KEY_W-1:0]  object_key;
    logic [sal_pkg::SIZE_W-1:0] object_size;
    modport source (output valid, req_type, object_key, object_size, input ready);
    modport sink   (input valid, req_type, object_key, object_size, output ready);
endinterface

interface sal_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic                        admitted;
    logic [sal_pkg::EVC_W-1:0]   evicted_count;
    logic [sal_pkg::BYTES_W-1:0] used_bytes;
    modport source (output valid, hit, admitted, evicted_count, used_bytes, input ready);
    modport sink   (input valid, hit, admitted, evicted_count, used_bytes, output ready);
endinterface

interface sal_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sal_pkg::CFG_IDX_W-1:0]  index;
    logic [sal_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/size_aware_lru_cache_core.sv
// ---------------------------------------------------------------------------
// size_aware_lru_cache_core: size-aware lru/fifo object cache
// Recency chain of cells under a byte capacity with tail eviction.
// ---------------------------------------------------------------------------
// Channels: req takes one item (req_type, object_key, object_size); rsp
// returns one item per request (hit, admitted, evicted_count, used_bytes).
// cfg writes a register at index 0..3 (capacity, policy, threshold enable,
// threshold); it is always ready and must be used while the block is idle.
// One item is handled at a time: accept, a match over all cells, a decide
// step, then for an admission the tail evictions and an insert, and done.
// The drop for a full row is made in the step that leaves the eviction
// state and takes no state of its own.
// A new item is accepted only once the last has passed match, decide and
// done and the block is back in idle; the chain takes a single broadcast
// command per cycle.
// The result sits in an output register; the next item is accepted while
// it waits, and a finished item waits in its last state while rsp stalls.
// Reset empties the chain and sets the registers to capacity 0, lru,
// threshold off and threshold 524288.
// ---------------------------------------------------------------------------
module size_aware_lru_cache_core #(
    parameter int unsigned ENTRIES = sal_pkg::ENTRIES_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    sal_req_if.sink   req,
    sal_rsp_if.source rsp,
    sal_cfg_if.sink   cfg
);

    // configuration registers
    logic [sal_pkg::BYTES_W-1:0] capacity_reg;
    logic                        policy_reg;
    logic                        thr_en_reg;
    logic [sal_pkg::THR_W-1:0]   threshold_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= '0;
            policy_reg    <= 1'b0;
            thr_en_reg    <= 1'b0;
            threshold_reg <= sal_pkg::THRESHOLD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sal_pkg::CFG_CAPACITY:   capacity_reg  <= cfg.data;
                sal_pkg::CFG_POLICY:     policy_reg    <= cfg.data[0];
                sal_pkg::CFG_THR_ENABLE: thr_en_reg    <= cfg.data[0];
                sal_pkg::CFG_THRESHOLD:  threshold_reg <= cfg.data[sal_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // state and working registers
    sal_pkg::ctrl_state_t        state_reg, state_next;
    logic [1:0]                  type_reg, type_next;
    logic [sal_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [sal_pkg::SIZE_W-1:0]  size_reg, size_next;
    logic [sal_pkg::BYTES_W-1:0] occ_reg, occ_next;
    logic                        hit_reg, hit_next;
    logic                        adm_reg, adm_next;
    logic [sal_pkg::EVC_W-1:0]   evc_reg, evc_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_hit_reg, out_hit_next;
    logic                        out_adm_reg, out_adm_next;
    logic [sal_pkg::EVC_W-1:0]   out_evc_reg, out_evc_next;
    logic [sal_pkg::BYTES_W-1:0] out_used_reg, out_used_next;

    sal_pkg::cell_cmd_t     cmd;
    sal_pkg::chain_status_t status;

    sal_chain #(.ENTRIES(ENTRIES)) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status)
    );

    logic [sal_pkg::BYTES_W:0]   need_bytes;
    logic                        over_cap;
    logic                        too_big;
    logic [sal_pkg::BYTES_W-1:0] occ_less_match;
    logic [sal_pkg::BYTES_W-1:0] occ_less_tail;
    logic [sal_pkg::EVC_W-1:0]   evc_inc;

    // byte arithmetic
    assign need_bytes = {1'b0, occ_reg} + {{(sal_pkg::BYTES_W-sal_pkg::SIZE_W+1){1'b0}}, size_reg};
    assign over_cap   = need_bytes > {1'b0, capacity_reg};
    assign too_big    = ({8'd0, size_reg} >= capacity_reg) ||
                        (thr_en_reg && ({2'd0, size_reg} >= threshold_reg));
    assign occ_less_match = (occ_reg >= {8'd0, status.match_size}) ?
                            occ_reg - {8'd0, status.match_size} : '0;
    assign occ_less_tail  = (occ_reg >= {8'd0, status.tail_size}) ?
                            occ_reg - {8'd0, status.tail_size} : '0;
    assign evc_inc = (evc_reg == sal_pkg::EVC_MAX) ? evc_reg : evc_reg + 7'd1;

    assign req.ready     = (state_reg == sal_pkg::ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.admitted  = out_adm_reg;
    assign rsp.evicted_count = out_evc_reg;
    assign rsp.used_bytes    = out_used_reg;

    // next state, chain command and result
    always_comb
    begin
        state_next     = state_reg;
        type_next      = type_reg;
        key_next       = key_reg;
        size_next      = size_reg;
        occ_next       = occ_reg;
        hit_next       = hit_reg;
        adm_next       = adm_reg;
        evc_next       = evc_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_hit_next   = out_hit_reg;
        out_adm_next   = out_adm_reg;
        out_evc_next   = out_evc_reg;
        out_used_next  = out_used_reg;
        cmd.op         = sal_pkg::OP_HOLD;
        cmd.key        = key_reg;
        cmd.size       = size_reg;
        case (state_reg)
            sal_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    type_next  = req.req_type;
                    key_next   = req.object_key;
                    size_next  = req.object_size;
                    hit_next   = 1'b0;
                    adm_next   = 1'b0;
                    evc_next   = '0;
                    state_next = sal_pkg::ST_LOOK;
                end
            end
            sal_pkg::ST_LOOK:
            begin
                cmd.op     = sal_pkg::OP_MATCH;
                state_next = sal_pkg::ST_DECIDE;
            end
            sal_pkg::ST_DECIDE:
            begin
                state_next = sal_pkg::ST_DONE;
                case (type_reg)
                    sal_pkg::REQ_ACCESS:
                    begin
                        if (status.match_any && status.match_size == size_reg)
                        begin
                            hit_next = 1'b1;
                            if (!policy_reg)
                                cmd.op = sal_pkg::OP_TO_FRONT;
                        end
                        else
                        begin
                            if (status.match_any)
                            begin
                                cmd.op   = sal_pkg::OP_REMOVE;
                                occ_next = occ_less_match;
                            end
                            if (!too_big)
                                state_next = sal_pkg::ST_EVICT;
                        end
                    end
                    sal_pkg::REQ_EVICT:
                    begin
                        if (status.match_any)
                        begin
                            hit_next = 1'b1;
                            cmd.op   = sal_pkg::OP_REMOVE;
                            occ_next = occ_less_match;
                        end
                    end
                    sal_pkg::REQ_LOOKUP:
                    begin
                        hit_next = status.match_any;
                    end
                    default:
                    begin
                    end
                endcase
            end
            sal_pkg::ST_EVICT:
            begin
                // drop the tail for bytes, then once more if every slot is taken
                if (over_cap && status.front_valid)
                begin
                    cmd.op   = sal_pkg::OP_DROP_TAIL;
                    occ_next = occ_less_tail;
                    evc_next = evc_inc;
                end
                else
                begin
                    if (status.last_valid)
                    begin
                        cmd.op   = sal_pkg::OP_DROP_TAIL;
                        occ_next = occ_less_tail;
                        evc_next = evc_inc;
                    end
                    state_next = sal_pkg::ST_INSERT;
                end
            end
            sal_pkg::ST_INSERT:
            begin
                cmd.op     = sal_pkg::OP_INSERT;
                occ_next   = need_bytes[sal_pkg::BYTES_W-1:0];
                adm_next   = 1'b1;
                state_next = sal_pkg::ST_DONE;
            end
            sal_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_adm_next   = adm_reg;
                    out_evc_next   = evc_reg;
                    out_used_next  = occ_reg;
                    state_next     = sal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sal_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sal_pkg::ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        type_reg     <= type_next;
        key_reg      <= key_next;
        size_reg     <= size_next;
        hit_reg      <= hit_next;
        adm_reg      <= adm_next;
        evc_reg      <= evc_next;
        out_hit_reg  <= out_hit_next;
        out_adm_reg  <= out_adm_next;
        out_evc_reg  <= out_evc_next;
        out_used_reg <= out_used_next;
    end

endmodule

>>> src/sal_cell.sv
// ---------------------------------------------------------------------------
// sal_cell: one recency slot of the cache chain
// Holds one entry; shifts toward the front or tail as commanded.
// ---------------------------------------------------------------------------
module sal_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sal_pkg::cell_cmd_t  cmd,
    input  sal_pkg::entry_t     left,
    input  sal_pkg::entry_t     right,
    input  logic                seen_in,
    output logic                seen_out,
    output sal_pkg::entry_t     cur,
    output logic                match,
    output logic                is_tail
);

    logic                       valid_reg, valid_next;
    logic [sal_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [sal_pkg::SIZE_W-1:0] size_reg, size_next;
    logic                       match_reg, match_next;

    assign cur      = '{valid: valid_reg, key: key_reg, size: size_reg};
    assign match    = match_reg;
    assign seen_out = seen_in | match_reg;
    assign is_tail  = valid_reg & ~right.valid;

    // next entry per broadcast op
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        size_next  = size_reg;
        match_next = match_reg;
        case (cmd.op)
            sal_pkg::OP_MATCH:
            begin
                match_next = valid_reg && (key_reg == cmd.key);
            end
            sal_pkg::OP_REMOVE:
            begin
                if (seen_out)
                begin
                    valid_next = right.valid;
                    key_next   = right.key;
                    size_next  = right.size;
                end
            end
            sal_pkg::OP_TO_FRONT:
            begin
                if (!seen_in)
                begin
                    valid_next = left.valid;
                    key_next   = left.key;
                    size_next  = left.size;
                end
            end
            sal_pkg::OP_INSERT:
            begin
                valid_next = left.valid;
                key_next   = left.key;
                size_next  = left.size;
            end
            sal_pkg::OP_DROP_TAIL:
            begin
                if (is_tail)
                    valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        size_reg <= size_next;
    end

endmodule

>>> src/sal_chain.sv
// ---------------------------------------------------------------------------
// sal_chain: row of cells ordered by recency
// Cell 0 is the front, valid entries are packed from the front.
// ---------------------------------------------------------------------------
module sal_chain #(
    parameter int unsigned ENTRIES = sal_pkg::ENTRIES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sal_pkg::cell_cmd_t     cmd,
    output sal_pkg::chain_status_t status
);

    sal_pkg::entry_t cur   [ENTRIES];
    sal_pkg::entry_t left  [ENTRIES];
    sal_pkg::entry_t right [ENTRIES];
    logic            seen  [ENTRIES+1];
    logic [ENTRIES-1:0] match_vec, tail_vec;

    assign seen[0] = 1'b0;

    // neighbor wiring, cell 0 sees the new front entry
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_front
                assign left[g] = '{valid: 1'b1, key: cmd.key, size: cmd.size};
            end
            else
            begin : g_mid
                assign left[g] = cur[g-1];
            end
            if (g == ENTRIES-1)
            begin : g_last
                assign right[g] = '0;
            end
            else
            begin : g_inner
                assign right[g] = cur[g+1];
            end
            sal_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .left     (left[g]),
                .right    (right[g]),
                .seen_in  (seen[g]),
                .seen_out (seen[g+1]),
                .cur      (cur[g]),
                .match    (match_vec[g]),
                .is_tail  (tail_vec[g])
            );
        end
    endgenerate

    // status gathered over the one-hot match and tail flags
    always_comb
    begin
        status.match_any   = |match_vec;
        status.match_size  = '0;
        status.tail_size   = '0;
        status.front_valid = cur[0].valid;
        status.last_valid  = cur[ENTRIES-1].valid;
        for (int i = 0; i < ENTRIES; i++)
        begin
            status.match_size = status.match_size | (cur[i].size & {sal_pkg::SIZE_W{match_vec[i]}});
            status.tail_size  = status.tail_size | (cur[i].size & {sal_pkg::SIZE_W{tail_vec[i]}});
        end
    end

endmodule

>>> src/sal_checker.sv
// ---------------------------------------------------------------------------
// sal_checker: port-level checks of the cache core
// Watches the response channel over time.
// ---------------------------------------------------------------------------
module sal_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_hit,
    input logic                        rsp_admitted,
    input logic [sal_pkg::EVC_W-1:0]   rsp_evicted_count,
    input logic [sal_pkg::BYTES_W-1:0] rsp_used_bytes
);

    // stalled item holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_used_bytes))
        else $error("response changed while stalled");

    // an admitted item was a miss
    a_adm_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_admitted |-> !rsp_hit)
        else $error("admitted on a hit");

    // evictions happen only on the way to an admission
    a_evict_adm: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_admitted |-> rsp_evicted_count == '0)
        else $error("evictions without admission");

endmodule

bind size_aware_lru_cache_core sal_checker u_sal_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_hit           (rsp.hit),
    .rsp_admitted      (rsp.admitted),
    .rsp_evicted_count (rsp.evicted_count),
    .rsp_used_bytes    (rsp.used_bytes)
);
